### rtl/olief_pkg.sv
// olief_pkg: shared constants, codes and types of the ordered list block
// used by olief_cell, olief_chain and ordered_list_insert_erase_find
`timescale 1ns / 1ps
`default_nettype none

package olief_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int STAT_W = 3;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
   localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd6;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

   // per-cell load select
   localparam logic [1:0] ACT_HOLD  = 2'd0;
   localparam logic [1:0] ACT_LEFT  = 2'd1;
   localparam logic [1:0] ACT_RIGHT = 2'd2;
   localparam logic [1:0] ACT_VALUE = 2'd3;

   // edit broadcast to the cell row
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [CNT_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } edit_type;

endpackage

`default_nettype wire

### rtl/olief_cell.sv
// olief_cell: one list entry with its neighbor load mux and key compare
// depends on olief_pkg
`timescale 1ns / 1ps
`default_nettype none

module olief_cell (
   input  wire logic                       clock,
   input  wire logic [1:0]                 action,
   input  wire logic [olief_pkg::DATA_W-1:0] left_data,
   input  wire logic [olief_pkg::DATA_W-1:0] right_data,
   input  wire logic [olief_pkg::DATA_W-1:0] new_data,
   input  wire logic [olief_pkg::DATA_W-1:0] key,
   input  wire logic                       match_en,
   output logic      [olief_pkg::DATA_W-1:0] data,
   output logic                            match
);

   logic [olief_pkg::DATA_W-1:0] data_ff;
   logic [olief_pkg::DATA_W-1:0] data_in;
   logic                         match_ff;

   always_comb begin
      case (action)
         olief_pkg::ACT_HOLD:  data_in = data_ff;
         olief_pkg::ACT_LEFT:  data_in = left_data;
         olief_pkg::ACT_RIGHT: data_in = right_data;
         olief_pkg::ACT_VALUE: data_in = new_data;
         default:              data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (match_en) begin
         match_ff <= (data_ff == key);
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

### rtl/olief_chain.sv
// olief_chain: row of olief_cell entries, per-cell shift select and dump read port
// depends on olief_pkg and olief_cell
`timescale 1ns / 1ps
`default_nettype none

module olief_chain (
   input  wire logic                          clock,
   input  wire olief_pkg::edit_type           edit,
   input  wire logic                          match_en,
   input  wire logic [olief_pkg::DATA_W-1:0]  key,
   input  wire logic [olief_pkg::IDX_W-1:0]   rd_idx,
   output logic      [olief_pkg::DEPTH-1:0]   match_vec,
   output logic      [olief_pkg::DATA_W-1:0]  rd_data
);

   logic [olief_pkg::DATA_W-1:0] cell_data [olief_pkg::DEPTH];

   for (genvar i = 0; i < olief_pkg::DEPTH; i++) begin : g_cell
      logic [1:0]                   action;
      logic [olief_pkg::DATA_W-1:0] left_data;
      logic [olief_pkg::DATA_W-1:0] right_data;

      always_comb begin
         action = olief_pkg::ACT_HOLD;
         if (edit.ins) begin
            if (olief_pkg::CNT_W'(i) > edit.pos) begin
               action = olief_pkg::ACT_LEFT;
            end else if (olief_pkg::CNT_W'(i) == edit.pos) begin
               action = olief_pkg::ACT_VALUE;
            end
         end else if (edit.del) begin
            if (olief_pkg::CNT_W'(i) >= edit.pos) begin
               action = olief_pkg::ACT_RIGHT;
            end
         end
      end

      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      // the tail cell pulls in its own value, it lies beyond the count after a removal
      if (i == olief_pkg::DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      olief_cell u_cell (
         .clock      (clock),
         .action     (action),
         .left_data  (left_data),
         .right_data (right_data),
         .new_data   (edit.value),
         .key        (key),
         .match_en   (match_en),
         .data       (cell_data[i]),
         .match      (match_vec[i])
      );
   end

   assign rd_data = cell_data[rd_idx];

endmodule

`default_nettype wire

### rtl/ordered_list_insert_erase_find.sv
// ordered_list_insert_erase_find: top level, command sequencer and result register
// depends on olief_pkg and olief_chain
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 16 signed 32-bit entries held in a row of shifting cells.
// Input: an item (req_opcode, req_position, req_value) is taken at a clock edge
// where start is high and busy is low. busy stays high while the item is worked.
// Output: each result is shown for one cycle with rsp_valid high; rsp_last marks
// the final result of an item. The receiver cannot stall, so nothing waits here.
// The result of a single-result item is worked in the S_EXEC state and then held
// in the result registers; a new item can be accepted while it is on the ports.
// Items do not overlap: busy stays high through the S_EXEC command state, in which
// the cells shift or the registered key-compare bits are priority encoded.
// A dump of n entries emits n results, one per cycle, reading the row through
// a single read port.
// Find compares every cell with the key in the accept cycle, then picks the
// lowest matching position below the count.
// Reset clears the count and the sequencer; the entries keep stale values that
// are never read at or beyond the count.

module ordered_list_insert_erase_find (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [olief_pkg::OP_W-1:0]   req_opcode,
   input  wire logic        [olief_pkg::CNT_W-1:0]  req_position,
   input  wire logic signed [olief_pkg::DATA_W-1:0] req_value,
   output logic                                     rsp_valid,
   output logic             [olief_pkg::STAT_W-1:0] rsp_status,
   output logic             [olief_pkg::CNT_W-1:0]  rsp_index,
   output logic signed      [olief_pkg::DATA_W-1:0] rsp_element,
   output logic             [olief_pkg::CNT_W-1:0]  rsp_count,
   output logic                                     rsp_last
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   localparam logic [olief_pkg::CNT_W-1:0] FULL_COUNT = olief_pkg::CNT_W'(olief_pkg::DEPTH);

   logic [1:0]                    state_ff, state_in;
   logic [olief_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [olief_pkg::CNT_W-1:0]   dump_idx_ff, dump_idx_in;
   logic [olief_pkg::OP_W-1:0]    op_ff;
   logic [olief_pkg::CNT_W-1:0]   pos_ff;
   logic [olief_pkg::DATA_W-1:0]  value_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [olief_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [olief_pkg::CNT_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [olief_pkg::DATA_W-1:0]  rsp_element_ff, rsp_element_in;
   logic [olief_pkg::CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          accept;
   logic                          full;
   logic                          empty;
   logic                          found;
   logic [olief_pkg::CNT_W-1:0]   found_idx;
   logic                          dump_end;
   olief_pkg::edit_type           edit;
   logic [olief_pkg::DEPTH-1:0]   match_vec;
   logic [olief_pkg::DATA_W-1:0]  rd_data;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);
   assign dump_end = (dump_idx_ff == count_ff - olief_pkg::CNT_W'(1));

   olief_chain u_chain (
      .clock     (clock),
      .edit      (edit),
      .match_en  (accept),
      .key       (req_value),
      .rd_idx    (dump_idx_ff[olief_pkg::IDX_W-1:0]),
      .match_vec (match_vec),
      .rd_data   (rd_data)
   );

   // lowest matching position below the count
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = olief_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i] && (olief_pkg::CNT_W'(i) < count_ff)) begin
            found     = 1'b1;
            found_idx = olief_pkg::CNT_W'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      edit           = '{ins: 1'b0, del: 1'b0, pos: '0, value: value_ff};
      rsp_valid_in   = 1'b0;
      rsp_status_in  = olief_pkg::STAT_OK;
      rsp_index_in   = '0;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               olief_pkg::OP_PUSH_BACK, olief_pkg::OP_PUSH_FRONT, olief_pkg::OP_INSERT: begin
                  if (full) begin
                     rsp_status_in = olief_pkg::STAT_FULL;
                  end else if (op_ff == olief_pkg::OP_INSERT && pos_ff > count_ff) begin
                     rsp_status_in = olief_pkg::STAT_BADPOS;
                  end else begin
                     edit.ins = 1'b1;
                     if (op_ff == olief_pkg::OP_PUSH_BACK) begin
                        edit.pos = count_ff;
                     end else if (op_ff == olief_pkg::OP_INSERT) begin
                        edit.pos = pos_ff;
                     end
                     count_in = count_ff + olief_pkg::CNT_W'(1);
                  end
               end
               olief_pkg::OP_POP_BACK: begin
                  if (empty) begin
                     rsp_status_in = olief_pkg::STAT_EMPTY;
                  end else begin
                     count_in = count_ff - olief_pkg::CNT_W'(1);
                  end
               end
               olief_pkg::OP_POP_FRONT, olief_pkg::OP_ERASE: begin
                  if (empty) begin
                     rsp_status_in = olief_pkg::STAT_EMPTY;
                  end else if (op_ff == olief_pkg::OP_ERASE && pos_ff >= count_ff) begin
                     rsp_status_in = olief_pkg::STAT_BADPOS;
                  end else begin
                     edit.del = 1'b1;
                     if (op_ff == olief_pkg::OP_ERASE) begin
                        edit.pos = pos_ff;
                     end
                     count_in = count_ff - olief_pkg::CNT_W'(1);
                  end
               end
               olief_pkg::OP_FIND: begin
                  if (empty) begin
                     rsp_status_in = olief_pkg::STAT_EMPTY;
                  end else if (found) begin
                     rsp_index_in = found_idx;
                  end else begin
                     rsp_status_in = olief_pkg::STAT_NOTFOUND;
                  end
               end
               olief_pkg::OP_DUMP: begin
                  if (empty) begin
                     rsp_status_in = olief_pkg::STAT_EMPTY;
                  end else begin
                     rsp_valid_in = 1'b0;
                     dump_idx_in  = '0;
                     state_in     = S_DUMP;
                  end
               end
               default: begin
                  rsp_status_in = olief_pkg::STAT_OK;
               end
            endcase
         end
         S_DUMP: begin
            rsp_valid_in   = 1'b1;
            rsp_index_in   = dump_idx_ff;
            rsp_element_in = rd_data;
            rsp_last_in    = dump_end;
            dump_idx_in    = dump_idx_ff + olief_pkg::CNT_W'(1);
            if (dump_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_count_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      dump_idx_ff    <= dump_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_last    = rsp_last_ff;

   // a dump result that is not the last one is followed by another in the next cycle
   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("dump stream broke before its last item");

   // mid-dump results only while the sequencer still holds the block busy
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("dump result without busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond depth");

   // every accepted item is worked in the following cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item not executed");

endmodule

`default_nettype wire
